@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of the color ramp block.
// No dependencies; take in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define CRI_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("color ramp check failed");

// Check that an antecedent implies a consequent in the same cycle.
`define CRI_ASSERT_IMP(name, clk, rstn, ante, cons) \
  `CRI_ASSERT(name, clk, rstn, (ante) |-> (cons))

// Check that an antecedent implies a consequent in the next cycle.
`define CRI_ASSERT_NXT(name, clk, rstn, ante, cons) \
  `CRI_ASSERT(name, clk, rstn, (ante) |=> (cons))

`endif

@@ rtl/cri_pkg.sv @@
// Types and codes of the color ramp interpolator.
// No dependencies; used by the core, the blend stage and the checker.
package cri_pkg;

  typedef enum logic [2:0] {
    OP_CLAMP     = 3'd0,
    OP_RING      = 3'd1,
    OP_APPEND    = 3'd2,
    OP_OVERWRITE = 3'd3,
    OP_READ      = 3'd4
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_READ = 4'b0100,
    ST_MIX  = 4'b1000
  } state_e;

  localparam int unsigned ColorW = 24;
  localparam int unsigned FracW  = 16;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] position;
    logic [7:0]         stop_index;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       ok;
  } out_word_t;

  typedef struct packed {
    logic             fire;
    logic             ok;
    logic             clear;
    logic [FracW-1:0] frac;
  } blend_req_t;

endpackage

@@ rtl/color_ramp_interpolator_core.sv @@
// Color ramp interpolator core: stop table in RAM, sequencer and address logic.
// Depends on cri_pkg, cri_ram and cri_blend.
//
//   channel   ports                  handshake
//   command   start, req_i, busy     taken when start high and busy low
//   result    done_o, rsp_o          done_o high for one cycle, no back-pressure
//
// Each item is handled in steps: multiply the position by the stop count (by the
// last index for clamp), address the two RAM copies (writes happen here), blend the read data, then show.
// A new command may be taken in the cycle in which the previous result shows.
// Reset clears the state, the stop count and the blend request, not the table; entries are undefined until written.
module color_ramp_interpolator_core #(
  parameter int unsigned MAX_SPOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  cri_pkg::in_word_t  req_i,
  output logic               busy,
  output cri_pkg::out_word_t rsp_o,
  output logic               done_o
);
  import cri_pkg::*;

  localparam int unsigned IW   = $clog2(MAX_SPOTS);
  localparam int unsigned CW   = $clog2(MAX_SPOTS + 1);
  localparam int unsigned XW   = IW + 1;
  localparam int unsigned PW   = FracW + CW;
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;

  state_e            state_q, state_d;
  in_word_t          item_q;
  logic [CW-1:0]     count_q, count_d;
  logic [PW-1:0]     prod_q;
  logic [CW-1:0]     mult_b;
  logic [CW-1:0]     last_idx;
  blend_req_t        req_q, req_d;

  logic              we;
  logic [IW-1:0]     waddr, raddr_a, raddr_b;
  logic [ColorW-1:0] wdata, rdata_a, rdata_b;

  logic [IW-1:0]     seg;
  logic [XW-1:0]     seg_next;
  logic [IW-1:0]     ring_next;
  logic              idx_ok;

  assign busy     = (state_q != ST_IDLE);
  assign last_idx = count_q - CW'(1);
  assign mult_b   = (item_q.opcode == OP_CLAMP) ? last_idx : count_q;
  assign seg      = prod_q[FracW +: IW];
  assign seg_next = XW'(seg) + XW'(1);
  assign ring_next = (seg_next == XW'(count_q)) ? '0 : seg_next[IW-1:0];
  assign idx_ok   = CMPW'(item_q.stop_index) < CMPW'(count_q);
  assign wdata    = {item_q.in_red, item_q.in_green, item_q.in_blue};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_MUL;
      ST_MUL:  state_d = ST_READ;
      ST_READ: state_d = ST_MIX;
      ST_MIX:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    we      = 1'b0;
    waddr   = item_q.stop_index[IW-1:0];
    raddr_a = '0;
    raddr_b = '0;
    req_d   = '0;
    if (state_q == ST_READ) begin
      req_d.fire  = 1'b1;
      req_d.clear = 1'b1;
      case (item_q.opcode)
        OP_CLAMP: begin
          if (count_q != '0) begin
            req_d.ok    = 1'b1;
            req_d.clear = 1'b0;
            if (count_q == CW'(1) || item_q.position <= 32'sd0) begin
              raddr_a = '0;
              raddr_b = '0;
            end else if (item_q.position >= 32'sd65536) begin
              raddr_a = last_idx[IW-1:0];
              raddr_b = last_idx[IW-1:0];
            end else begin
              raddr_a    = seg;
              raddr_b    = seg_next[IW-1:0];
              req_d.frac = prod_q[FracW-1:0];
            end
          end
        end
        OP_RING: begin
          if (count_q != '0) begin
            req_d.ok    = 1'b1;
            req_d.clear = 1'b0;
            raddr_a     = seg;
            raddr_b     = ring_next;
            req_d.frac  = prod_q[FracW-1:0];
          end
        end
        OP_APPEND: begin
          if (count_q < CW'(MAX_SPOTS)) begin
            we       = 1'b1;
            waddr    = count_q[IW-1:0];
            count_d  = count_q + CW'(1);
            req_d.ok = 1'b1;
          end
        end
        OP_OVERWRITE: begin
          if (idx_ok) begin
            we       = 1'b1;
            req_d.ok = 1'b1;
          end
        end
        OP_READ: begin
          if (idx_ok) begin
            raddr_a     = item_q.stop_index[IW-1:0];
            raddr_b     = item_q.stop_index[IW-1:0];
            req_d.ok    = 1'b1;
            req_d.clear = 1'b0;
          end
        end
        default: begin
          req_d.ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      req_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      req_q   <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      item_q <= req_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= PW'(item_q.position[FracW-1:0]) * PW'(mult_b);
    end
  end

  cri_ram #(
    .Width(ColorW),
    .Depth(MAX_SPOTS)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr_a),
    .rdata_o(rdata_a)
  );

  cri_ram #(
    .Width(ColorW),
    .Depth(MAX_SPOTS)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr_b),
    .rdata_o(rdata_b)
  );

  cri_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_q),
    .color_a_i(rdata_a),
    .color_b_i(rdata_b),
    .rsp_o    (rsp_o),
    .done_o   (done_o)
  );

endmodule

@@ rtl/cri_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cri_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cri_blend.sv @@
// Blend stage: mixes two stop colors by a 16-bit fraction and holds the result word.
// Depends on cri_pkg. A clear request gives a zero color.
module cri_blend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cri_pkg::blend_req_t           req_i,
  input  logic [cri_pkg::ColorW-1:0]    color_a_i,
  input  logic [cri_pkg::ColorW-1:0]    color_b_i,
  output cri_pkg::out_word_t            rsp_o,
  output logic                          done_o
);
  import cri_pkg::*;

  function automatic logic [7:0] mix8(logic [7:0] a, logic [7:0] b, logic [FracW-1:0] f);
    logic [24:0] acc;
    acc = 25'(a) * 25'(17'h10000 - 17'(f)) + 25'(b) * 25'(f) + 25'd32768;
    return acc[23:16];
  endfunction

  out_word_t rsp_d, rsp_q;
  logic      done_q;

  always_comb begin
    rsp_d.ok = req_i.ok;
    if (req_i.clear) begin
      rsp_d.out_red   = '0;
      rsp_d.out_green = '0;
      rsp_d.out_blue  = '0;
    end else begin
      rsp_d.out_red   = mix8(color_a_i[23:16], color_b_i[23:16], req_i.frac);
      rsp_d.out_green = mix8(color_a_i[15:8],  color_b_i[15:8],  req_i.frac);
      rsp_d.out_blue  = mix8(color_a_i[7:0],   color_b_i[7:0],   req_i.frac);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.fire) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_i.fire;
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

@@ rtl/cri_checker.sv @@
// Port-level checks of the color ramp interpolator core, bound to the core module.
// Depends on cri_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cri_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input cri_pkg::out_word_t rsp_o
);
  import cri_pkg::*;

  logic [ColorW-1:0] rsp_rgb;

  assign rsp_rgb = {rsp_o.out_red, rsp_o.out_green, rsp_o.out_blue};

  `CRI_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `CRI_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy && $past(busy))
  `CRI_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `CRI_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, done_o && !rsp_o.ok, rsp_rgb == '0)

endmodule

bind color_ramp_interpolator_core cri_checker u_cri_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
